// ===== hdl/aket_pkg.sv =====
package aket_pkg;

    localparam int ENTRIES_DEFAULT = 64;

    localparam int COORD_W = 24;
    localparam int LEVEL_W = 5;
    localparam int KEY_W   = 3 * COORD_W + LEVEL_W;
    localparam int AGE_W   = 8;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;

    localparam logic [AGE_W-1:0] AGE_MAX        = {AGE_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
    localparam logic [AGE_W-1:0] MAX_IDLE_RESET = 8'd16;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic              hit;
        logic              created;
        logic              full_res;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  removed_count;
    } result_t;

endpackage

// ===== hdl/aket_ram.sv =====
module aket_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/aket_engine.sv =====
module aket_engine #(
    parameter int ENTRIES = aket_pkg::ENTRIES_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [aket_pkg::AGE_W-1:0]  max_idle,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  aket_pkg::cmd_t              req_command,
    input  logic [aket_pkg::KEY_W-1:0]  req_key,
    input  logic                        res_free,
    output logic                        res_load,
    output aket_pkg::result_t           res
);

    import aket_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
    localparam logic [CW-1:0] END_CNT   = CW'(ENTRIES);

    typedef enum logic [3:0] {
        ST_INIT   = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    cmd_t              cmd_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              pv_reg;
    logic [AW-1:0]     paddr_reg;
    logic              found_reg;
    logic [AW-1:0]     fslot_reg;
    logic              free_reg;
    logic [AW-1:0]     free_slot_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [KEY_W-1:0]  key_rd;
    logic [AGE_W:0]    age_rd;
    logic              key_we;
    logic [AW-1:0]     key_waddr;
    logic              age_we;
    logic [AW-1:0]     age_waddr;
    logic [AGE_W:0]    age_wdata;

    logic              ent_valid;
    logic [AGE_W-1:0]  ent_age;
    logic [AGE_W-1:0]  age_inc;
    logic [CNT_W-1:0]  cnt_inc;
    logic              key_match;
    logic              scan_end;
    logic              is_find;
    logic [AW-1:0]     slot_sel;
    logic [AW+SLOT_W-1:0] slot_ext;

    aket_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (idx_reg[AW-1:0]),
        .rdata (key_rd)
    );

    // valid bit sits above the age
    aket_ram #(.WIDTH(AGE_W + 1), .DEPTH(ENTRIES)) u_age_ram (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (age_rd)
    );

    assign ent_valid = age_rd[AGE_W];
    assign ent_age   = age_rd[AGE_W-1:0];
    assign age_inc   = (ent_age == AGE_MAX) ? ent_age : ent_age + 1'b1;
    assign cnt_inc   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign key_match = ent_valid && (key_rd == key_reg);
    assign scan_end  = pv_reg && (paddr_reg == LAST_ADDR);
    assign is_find   = (cmd_reg == CMD_REQUEST) || (cmd_reg == CMD_LOOKUP);
    assign req_stall = (state_reg != ST_IDLE);
    assign res_load  = (state_reg == ST_FINISH) && res_free;

    // memory writes: clearing pass, aging/clear write-back, request update
    always_comb
    begin
        key_we    = 1'b0;
        key_waddr = free_slot_reg;
        age_we    = 1'b0;
        age_waddr = paddr_reg;
        age_wdata = '0;
        case (state_reg)
            ST_INIT:
            begin
                age_we    = 1'b1;
                age_waddr = idx_reg[AW-1:0];
            end
            ST_SCAN:
            begin
                if (pv_reg && ent_valid)
                begin
                    if (cmd_reg == CMD_TICK)
                    begin
                        age_we = 1'b1;
                        if (age_inc <= max_idle)
                        begin
                            age_wdata = {1'b1, age_inc};
                        end
                    end
                    else if (cmd_reg == CMD_CLEAR)
                    begin
                        age_we = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                if (res_free && (cmd_reg == CMD_REQUEST))
                begin
                    age_wdata = {1'b1, {AGE_W{1'b0}}};
                    if (found_reg)
                    begin
                        age_we    = 1'b1;
                        age_waddr = fslot_reg;
                    end
                    else if (free_reg)
                    begin
                        age_we    = 1'b1;
                        age_waddr = free_slot_reg;
                        key_we    = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_INIT:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg[AW-1:0] == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                idx_next = '0;
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg != END_CNT)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            paddr_reg     <= '0;
            found_reg     <= 1'b0;
            fslot_reg     <= '0;
            free_reg      <= 1'b0;
            free_slot_reg <= '0;
            cnt_reg       <= '0;
            cmd_reg       <= CMD_REQUEST;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pv_reg    <= (state_reg == ST_SCAN) && (idx_reg != END_CNT);
            paddr_reg <= idx_reg[AW-1:0];
            if ((state_reg == ST_IDLE) && req_valid)
            begin
                cmd_reg   <= req_command;
                found_reg <= 1'b0;
                free_reg  <= 1'b0;
                cnt_reg   <= '0;
            end
            else if ((state_reg == ST_SCAN) && pv_reg)
            begin
                if (is_find && key_match && !found_reg)
                begin
                    found_reg <= 1'b1;
                    fslot_reg <= paddr_reg;
                end
                if (!ent_valid && !free_reg)
                begin
                    free_reg      <= 1'b1;
                    free_slot_reg <= paddr_reg;
                end
                if (ent_valid && (((cmd_reg == CMD_TICK) && (age_inc > max_idle))
                                  || (cmd_reg == CMD_CLEAR)))
                begin
                    cnt_reg <= cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && req_valid)
        begin
            key_reg <= req_key;
        end
    end

    // result fields
    always_comb
    begin
        res.hit      = is_find && found_reg;
        res.created  = (cmd_reg == CMD_REQUEST) && !found_reg && free_reg;
        res.full_res = (cmd_reg == CMD_REQUEST) && !found_reg && !free_reg;
        if (res.hit)
        begin
            slot_sel = fslot_reg;
        end
        else if (res.created)
        begin
            slot_sel = free_slot_reg;
        end
        else
        begin
            slot_sel = '0;
        end
        slot_ext          = {{SLOT_W{1'b0}}, slot_sel};
        res.slot          = slot_ext[SLOT_W-1:0];
        res.removed_count = cnt_reg;
    end

endmodule

// ===== hdl/aging_keyed_entry_table.sv =====
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ---------------------------------------------
// input     in         in_valid / in_stall    command, pos_x, pos_y, pos_z, detail_level
// result    out        out_valid / out_stall  hit, created, full_res, slot, removed_count
// config    in         cfg_wr_en              cfg_wr_data (max_idle_ticks)
//
// Between accepts a command passes through the idle state that takes the request, a scan that
// reads every entry in turn and takes in the last read data, and a finish state that writes
// back a request and loads the result register.
// After reset a clearing pass frees every entry; every command stalls during it.
// A stalled result holds in the output register while the next request is swept; that
// request then waits in its final cycle until the register frees.
module aging_keyed_entry_table #(
    parameter int ENTRIES = aket_pkg::ENTRIES_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [aket_pkg::AGE_W-1:0]             cfg_wr_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             command,
    input  logic signed [aket_pkg::COORD_W-1:0]    pos_x,
    input  logic signed [aket_pkg::COORD_W-1:0]    pos_y,
    input  logic signed [aket_pkg::COORD_W-1:0]    pos_z,
    input  logic [aket_pkg::LEVEL_W-1:0]           detail_level,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   hit,
    output logic                                   created,
    output logic                                   full_res,
    output logic [aket_pkg::SLOT_W-1:0]            slot,
    output logic [aket_pkg::CNT_W-1:0]             removed_count
);

    import aket_pkg::*;

    logic [AGE_W-1:0] max_idle_reg;
    logic             out_valid_reg;
    result_t          res_reg;
    result_t          res;
    logic             res_load;
    logic             res_free;
    logic [KEY_W-1:0] in_key;

    // key is compared as a raw bit pattern
    assign in_key = {pos_x, pos_y, pos_z, detail_level};

    // the output register is free once empty or being taken this cycle
    assign res_free = !out_valid_reg || !out_stall;

    aket_engine #(.ENTRIES(ENTRIES)) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_idle    (max_idle_reg),
        .req_valid   (in_valid),
        .req_stall   (in_stall),
        .req_command (cmd_t'(command)),
        .req_key     (in_key),
        .res_free    (res_free),
        .res_load    (res_load),
        .res         (res)
    );

    // idle limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_idle_reg <= MAX_IDLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_idle_reg <= cfg_wr_data;
        end
    end

    // result register: load on completion, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = res_reg.hit;
    assign created       = res_reg.created;
    assign full_res      = res_reg.full_res;
    assign slot          = res_reg.slot;
    assign removed_count = res_reg.removed_count;

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

    // one request is worked on at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while the previous one is in flight");

    // at most one outcome flag per result
    a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($countones({hit, created, full_res}) <= 1))
        else $error("conflicting outcome flags");

    // removal counts only come from tick or clear
    a_count_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (removed_count != '0)) |-> (!hit && !created && !full_res && (slot == '0)))
        else $error("removal count alongside a lookup outcome");

endmodule
